>>> rtl/cft_pkg.sv
// Shared types, constants and helpers for the frustum cull test block.
`default_nettype none

package cft_pkg;

	localparam int PLANES    = 6;
	localparam int PLANE_IDX_W = $clog2(PLANES);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	localparam int COORD_W   = 22;
	localparam int RAD_W     = 21;
	localparam int NRM_W     = 14;
	localparam int OFS_W     = 22;
	// Q2.12 * Q14.8 gives Q.20; offset and radius are lined up by 12 bits.
	localparam int FRAC_ALIGN = 12;
	localparam int PROD_W    = NRM_W + COORD_W;
	localparam int DIST_W    = PROD_W + 1;

	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [PLANES-1:0] MARK_ANY_RST = '0;
	localparam logic [PLANES-1:0] MARK_ALL_RST = '1;

	typedef enum logic [1:0] {
		ACT_POINT  = 2'd0,
		ACT_SPHERE = 2'd1,
		ACT_CORNER = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		V_OUTSIDE   = 2'd0,
		V_INTERSECT = 2'd1,
		V_INSIDE    = 2'd2
	} verdict_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] d;
		logic signed [NRM_W-1:0] nz;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		action_t                   action;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [RAD_W-1:0]          radius;
		logic                      last_corner;
	} item_t;

	typedef struct packed {
		logic [Q_CNT_W-1:0] count;
		logic               full;
	} q_status_t;

	function automatic plane_t unpack_plane(input logic [CFG_W-1:0] raw);
		plane_t pl;
		pl.nx = raw[NRM_W-1:0];
		pl.ny = raw[2*NRM_W-1:NRM_W];
		pl.nz = raw[3*NRM_W-1:2*NRM_W];
		pl.d  = raw[CFG_W-1:3*NRM_W];
		return pl;
	endfunction

endpackage

`default_nettype wire

>>> rtl/cft_front.sv
// Front end: accepts items, drops unused action codes, queues the rest.
`default_nettype none

module cft_front
	import cft_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire item_t     in_item,
	output logic           q_valid,
	input  wire logic      q_pop,
	output item_t          q_item,
	output q_status_t      q_status
);

	item_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 push;
	logic                 pop;
	logic                 keep;

	always_comb begin
		case (in_item.action)
			ACT_POINT, ACT_SPHERE, ACT_CORNER: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign in_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	assign q_status.count = count_q;
	assign q_status.full  = !in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			count_q <= count_q + Q_CNT_W'(push) - Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_item;
	end

endmodule

`default_nettype wire

>>> rtl/cft_back.sv
// Back end: plane distances over two stages, then classification and box marks.
`default_nettype none

module cft_back
	import cft_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire plane_t planes [PLANES],
	input  wire logic   q_valid,
	output logic        q_pop,
	input  wire item_t  q_item,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [1:0]  verdict
);

	logic                       en;

	logic                       v_s1;
	logic signed [PROD_W-1:0]   prod_s1 [PLANES][3];
	action_t                    act_s1;
	logic                       last_s1;
	logic [RAD_W-1:0]           rad_s1;

	logic                       v_s2;
	logic signed [DIST_W-1:0]   dist_s2 [PLANES];
	logic signed [DIST_W-1:0]   rad_s2;
	action_t                    act_s2;
	logic                       last_s2;

	logic [PLANES-1:0]          any_q;
	logic [PLANES-1:0]          all_q;
	logic [PLANES-1:0]          neg;
	logic [PLANES-1:0]          below;
	logic [PLANES-1:0]          near;
	logic [PLANES-1:0]          any_nx;
	logic [PLANES-1:0]          all_nx;
	logic                       res_valid;
	logic                       mark_upd;
	verdict_t                   res;

	logic                       out_valid_q;
	verdict_t                   verdict_q;

	// whole pipeline moves together; it holds only while a result waits
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < PLANES; p++) begin
				prod_s1[p][0] <= PROD_W'(planes[p].nx) * PROD_W'(q_item.pos_x);
				prod_s1[p][1] <= PROD_W'(planes[p].ny) * PROD_W'(q_item.pos_y);
				prod_s1[p][2] <= PROD_W'(planes[p].nz) * PROD_W'(q_item.pos_z);
			end
			act_s1  <= q_item.action;
			last_s1 <= q_item.last_corner;
			rad_s1  <= q_item.radius;

			for (int p = 0; p < PLANES; p++) begin
				dist_s2[p] <= DIST_W'(prod_s1[p][0]) + DIST_W'(prod_s1[p][1])
					+ DIST_W'(prod_s1[p][2])
					+ DIST_W'($signed({planes[p].d, {FRAC_ALIGN{1'b0}}}));
			end
			rad_s2  <= DIST_W'($signed({1'b0, rad_s1, {FRAC_ALIGN{1'b0}}}));
			act_s2  <= act_s1;
			last_s2 <= last_s1;

			verdict_q <= res;
		end
	end

	always_comb begin
		for (int p = 0; p < PLANES; p++) begin
			neg[p]   = dist_s2[p][DIST_W-1];
			below[p] = dist_s2[p] < -rad_s2;
			near[p]  = dist_s2[p] <= rad_s2;
		end
		any_nx = any_q | ~neg;
		all_nx = all_q & ~neg;

		res_valid = 1'b0;
		mark_upd  = 1'b0;
		res       = V_INSIDE;
		case (act_s2)
			ACT_POINT: begin
				res_valid = 1'b1;
				res       = (|neg) ? V_OUTSIDE : V_INSIDE;
			end
			ACT_SPHERE: begin
				res_valid = 1'b1;
				// an outside plane wins over any touching one
				if (|below)
					res = V_OUTSIDE;
				else if (|near)
					res = V_INTERSECT;
				else
					res = V_INSIDE;
			end
			ACT_CORNER: begin
				mark_upd  = 1'b1;
				res_valid = last_s2;
				if (any_nx != MARK_ALL_RST)
					res = V_OUTSIDE;
				else if (all_nx == MARK_ALL_RST)
					res = V_INSIDE;
				else
					res = V_INTERSECT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= MARK_ANY_RST;
			all_q <= MARK_ALL_RST;
		end else if (en && v_s2 && mark_upd) begin
			if (last_s2) begin
				any_q <= MARK_ANY_RST;
				all_q <= MARK_ALL_RST;
			end else begin
				any_q <= any_nx;
				all_q <= all_nx;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule

`default_nettype wire

>>> rtl/frustum_cull_test.sv
// Top level: plane registers, front queue and back pipeline of the cull test.
//
//  channel | signals                                      | dir | moves
//  in      | in_valid/in_ready, action, pos_*, radius,    | in  | one item per accept
//          | last_corner                                  |     |
//  out     | out_valid/out_ready, verdict                 | out | one verdict per point, sphere or box
//  cfg     | cfg_we, cfg_index, cfg_data                  | in  | one plane per write
//
// Sustains one item per cycle while verdicts are taken; a point, sphere or last
// corner raises its verdict through the queue, products, distances and output register.
// A four-entry queue splits accept from the back pipeline, so input keeps
// flowing for up to four more items once the back pipeline holds; the back
// pipeline holds as a whole while its output register is full and not taken.
// Reset clears the planes to zero, the queue and all valids, and resets the box marks.
`default_nettype none

module frustum_cull_test
	import cft_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 action,
	input  wire logic signed [COORD_W-1:0]  pos_x,
	input  wire logic signed [COORD_W-1:0]  pos_y,
	input  wire logic signed [COORD_W-1:0]  pos_z,
	input  wire logic [RAD_W-1:0]           radius,
	input  wire logic                       last_corner,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      verdict,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data
);

	logic [CFG_W-1:0] plane_q [PLANES];
	plane_t           planes [PLANES];
	item_t            in_item;
	item_t            q_item;
	logic             q_valid;
	logic             q_pop;
	q_status_t        q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLANES; p++)
				plane_q[p] <= '0;
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(PLANES))) begin
			plane_q[cfg_index[PLANE_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int p = 0; p < PLANES; p++)
			planes[p] = unpack_plane(plane_q[p]);
	end

	always_comb begin
		in_item.action      = action_t'(action);
		in_item.pos_x       = pos_x;
		in_item.pos_y       = pos_y;
		in_item.pos_z       = pos_z;
		in_item.radius      = radius;
		in_item.last_corner = last_corner;
	end

	cft_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.q_status (q_status)
	);

	cft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.planes    (planes),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

`ifndef SYNTHESIS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");

	a_drop_none: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_NONE) |=>
		q_status.count <= $past(q_status.count))
		else $error("unused action code entered the queue");

	a_full_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !in_ready && q_valid)
		else $error("full queue still accepting or not offering");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict != 2'd3)
		else $error("undefined verdict code");
`endif

endmodule

`default_nettype wire
